// ----- rtl/mi3_pkg.sv -----
// Shared types and constants for the 3x3 matrix inverse unit.
package mi3_pkg;

    localparam int DataWidthDef  = 32;
    localparam int FracBitsDef   = 16;
    localparam int QueueDepthDef = 4;
    localparam int ElemCount     = 9;

    // Element indexes a, b, c, d of each cofactor a*b - c*d, already transposed.
    localparam int CofIdx [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic signed [31:0] m_00;
        logic signed [31:0] m_01;
        logic signed [31:0] m_02;
        logic signed [31:0] m_10;
        logic signed [31:0] m_11;
        logic signed [31:0] m_12;
        logic signed [31:0] m_20;
        logic signed [31:0] m_21;
        logic signed [31:0] m_22;
    } t_mat_in;

    typedef struct packed {
        logic signed [31:0] inv_00;
        logic signed [31:0] inv_01;
        logic signed [31:0] inv_02;
        logic signed [31:0] inv_10;
        logic signed [31:0] inv_11;
        logic signed [31:0] inv_12;
        logic signed [31:0] inv_20;
        logic signed [31:0] inv_21;
        logic signed [31:0] inv_22;
        logic               singular;
        logic               saturated;
    } t_inv_out;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ----- rtl/mi3_front.sv -----
// Front pipeline: input register, cofactors and determinant.
module mi3_front #(
    parameter int DATA_WIDTH = mi3_pkg::DataWidthDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_en,
    input  mi3_pkg::t_mat_in      i_item,
    input  mi3_pkg::t_fifo_stat   i_qstat,
    output logic                  o_qpush,
    output logic [9*(2*DATA_WIDTH+1)+3*DATA_WIDTH+2:0] o_qdata
);
    import mi3_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int NSTG = 6;

    logic [NSTG-1:0]        r_vld;
    logic signed [DW-1:0]   w_in [9];
    logic signed [DW-1:0]   r_e [9];
    logic signed [DW-1:0]   r_row1 [3];
    logic signed [DW-1:0]   r_row2 [3];
    logic signed [2*DW-1:0] r_pa [9];
    logic signed [2*DW-1:0] r_pb [9];
    logic signed [CW-1:0]   r_adj2 [9];
    logic signed [CW-1:0]   r_adj3 [9];
    logic signed [CW-1:0]   r_adj4 [9];
    logic signed [CW-1:0]   r_adj5 [9];
    logic signed [2*DW:0]   r_lo [3];
    logic signed [2*DW:0]   r_hi [3];
    logic signed [DETW-1:0] r_t [3];
    logic signed [DETW-1:0] r_det;

    // The whole pipeline advances unless a finished item waits on a full queue.
    assign o_en    = !r_vld[NSTG-1] || !i_qstat.full;
    assign o_qpush = r_vld[NSTG-1] && !i_qstat.full;

    assign w_in[0] = i_item.m_00[DW-1:0];
    assign w_in[1] = i_item.m_01[DW-1:0];
    assign w_in[2] = i_item.m_02[DW-1:0];
    assign w_in[3] = i_item.m_10[DW-1:0];
    assign w_in[4] = i_item.m_11[DW-1:0];
    assign w_in[5] = i_item.m_12[DW-1:0];
    assign w_in[6] = i_item.m_20[DW-1:0];
    assign w_in[7] = i_item.m_21[DW-1:0];
    assign w_in[8] = i_item.m_22[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (o_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_push};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_e    <= w_in;
            r_row1 <= r_e[0:2];
            r_row2 <= r_row1;
            r_adj3 <= r_adj2;
            r_adj4 <= r_adj3;
            r_adj5 <= r_adj4;
            r_det  <= r_t[0] + r_t[1] + r_t[2];
        end
    end

    for (genvar k = 0; k < ElemCount; k++) begin : g_cof
        always_ff @(posedge i_clk) begin
            if (o_en) begin
                r_pa[k]   <= r_e[CofIdx[k][0]] * r_e[CofIdx[k][1]];
                r_pb[k]   <= r_e[CofIdx[k][2]] * r_e[CofIdx[k][3]];
                r_adj2[k] <= CW'(r_pa[k]) - CW'(r_pb[k]);
            end
        end
        assign o_qdata[k*CW +: CW] = r_adj5[k];
    end

    // Determinant: first-row cofactors split into low and high halves so that
    // each product stays near element width.
    for (genvar j = 0; j < 3; j++) begin : g_det
        always_ff @(posedge i_clk) begin
            if (o_en) begin
                r_lo[j] <= $signed({1'b0, r_adj2[3*j][DW-1:0]}) * r_row2[j];
                r_hi[j] <= $signed(r_adj2[3*j][CW-1:DW]) * r_row2[j];
                r_t[j]  <= (DETW'(r_hi[j]) <<< DW) + DETW'(r_lo[j]);
            end
        end
    end

    assign o_qdata[9*CW +: DETW] = r_det;

endmodule

// ----- rtl/mi3_queue.sv -----
// Short register queue between the front and back pipelines.
module mi3_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mi3_pkg::QueueDepthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [WIDTH-1:0]    i_data,
    input  logic                i_pop,
    output logic [WIDTH-1:0]    o_data,
    output mi3_pkg::t_fifo_stat o_stat
);
    import mi3_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [NW-1:0]    r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_stat.full  = (r_cnt == NW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_wr   = i_push && !o_stat.full;
    assign w_rd   = i_pop && !o_stat.empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- rtl/mi3_back.sv -----
// Back pipeline: one quotient bit per stage for nine lanes, then saturation.
module mi3_back #(
    parameter int DATA_WIDTH = mi3_pkg::DataWidthDef,
    parameter int FRAC_BITS  = mi3_pkg::FracBitsDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mi3_pkg::t_fifo_stat i_qstat,
    input  logic [9*(2*DATA_WIDTH+1)+3*DATA_WIDTH+2:0] i_qdata,
    output logic                o_qpop,
    input  logic                i_pop,
    output logic                o_empty,
    output mi3_pkg::t_inv_out   o_item
);
    import mi3_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int NUMW = 2 * DW + 2 * FRAC_BITS;
    localparam int DIVW = ((NUMW > 4 * DW + 3) ? NUMW : 4 * DW + 3) + 1;
    localparam int NST  = DW + 3;
    localparam int LST  = DW + 1;
    localparam logic [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] POS_LIM = {1'b0, {(DW-1){1'b1}}};

    logic [NST-1:0]         r_vld;
    logic                   w_en;
    logic signed [CW-1:0]   w_adj [9];
    logic [CW-1:0]          w_amag [9];
    logic signed [DETW-1:0] w_det;
    logic [DIVW-1:0]        r_rem [LST+1][9];
    logic [DW-1:0]          r_q [LST+1][9];
    logic                   r_neg [LST+1][9];
    logic                   r_big [LST+1][9];
    logic [DETW-1:0]        r_dmag [LST+1];
    logic                   r_zero [LST+1];
    logic signed [31:0]     w_val [9];
    logic [8:0]             w_sat;
    t_inv_out               w_out;
    t_inv_out               r_out;

    assign w_en    = !r_vld[NST-1] || i_pop;
    assign o_qpop  = w_en && !i_qstat.empty;
    assign o_empty = !r_vld[NST-1];
    assign o_item  = r_out;
    assign w_det   = i_qdata[9*CW +: DETW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], o_qpop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dmag[0] <= w_det[DETW-1] ? -w_det : w_det;
            r_zero[0] <= (w_det == '0);
            for (int s = 1; s <= LST; s++) begin
                r_dmag[s] <= r_dmag[s-1];
                r_zero[s] <= r_zero[s-1];
            end
            r_out <= w_out;
        end
    end

    for (genvar k = 0; k < ElemCount; k++) begin : g_lane
        assign w_adj[k]  = i_qdata[k*CW +: CW];
        assign w_amag[k] = w_adj[k][CW-1] ? -w_adj[k] : w_adj[k];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[0][k] <= DIVW'(w_amag[k]) << (2 * FRAC_BITS);
                r_q[0][k]   <= '0;
                r_neg[0][k] <= w_adj[k][CW-1] ^ w_det[DETW-1];
                r_big[0][k] <= 1'b0;
                // Quotient of 2^DW or more saturates whatever its low bits are.
                r_rem[1][k] <= r_rem[0][k];
                r_q[1][k]   <= '0;
                r_neg[1][k] <= r_neg[0][k];
                r_big[1][k] <= (r_rem[0][k] >= (DIVW'(r_dmag[0]) << DW));
            end
        end

        for (genvar s = 2; s <= LST; s++) begin : g_bit
            logic [DIVW-1:0] w_trial;
            logic            w_ge;
            assign w_trial = DIVW'(r_dmag[s-1]) << (LST - s);
            assign w_ge    = (r_rem[s-1][k] >= w_trial);
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_rem[s][k] <= w_ge ? r_rem[s-1][k] - w_trial : r_rem[s-1][k];
                    r_q[s][k]   <= r_q[s-1][k] | (DW'(w_ge) << (LST - s));
                    r_neg[s][k] <= r_neg[s-1][k];
                    r_big[s][k] <= r_big[s-1][k];
                end
            end
        end

        always_comb begin
            logic [DW-1:0] mag;
            mag = r_q[LST][k];
            if (r_neg[LST][k]) begin
                w_sat[k] = r_big[LST][k] || (mag > NEG_LIM);
                if (w_sat[k]) begin
                    mag = NEG_LIM;
                end
                w_val[k] = -$signed(32'(mag));
            end else begin
                w_sat[k] = r_big[LST][k] || (mag > POS_LIM);
                if (w_sat[k]) begin
                    mag = POS_LIM;
                end
                w_val[k] = $signed(32'(mag));
            end
            if (r_zero[LST]) begin
                w_val[k] = '0;
            end
        end
    end

    always_comb begin
        w_out.inv_00    = w_val[0];
        w_out.inv_01    = w_val[1];
        w_out.inv_02    = w_val[2];
        w_out.inv_10    = w_val[3];
        w_out.inv_11    = w_val[4];
        w_out.inv_12    = w_val[5];
        w_out.inv_20    = w_val[6];
        w_out.inv_21    = w_val[7];
        w_out.inv_22    = w_val[8];
        w_out.singular  = r_zero[LST];
        w_out.saturated = !r_zero[LST] && (|w_sat);
    end

endmodule

// ----- rtl/matrix3x3_inverse_unit.sv -----
// Top level of the pipelined 3x3 fixed-point matrix inverse unit.
//
// Usage: one 3x3 matrix per item enters on i_item (nine signed fixed-point
// elements, row-major) when push is high and full is low. The inverse, formed
// as the adjugate over the determinant, leaves on o_item while empty is low and
// is taken when pop is high. Each element is truncated toward zero and clipped
// to the signed DATA_WIDTH range, with saturated raised if any was clipped. A
// zero determinant gives singular high and all other fields zero.
// From the accepting edge, the item passes through six front stages for
// products, cofactors and the determinant, is then written into the queue,
// and follows DATA_WIDTH + 3 back stages: a load stage, a stage that flags
// quotients of 2^DATA_WIDTH or more, the quotient-bit stages that each
// resolve one quotient bit for all nine elements, and an output register.
// One item is accepted per cycle while full is low.
// When the receiver stalls, the back pipeline holds, the queue between the
// halves fills, and only then does full rise; the front keeps accepting items
// until the queue is full and a finished item waits at the end of the front.
// Reset clears all valid flags and queue pointers; no clearing pass is needed.
module matrix3x3_inverse_unit #(
    parameter int DATA_WIDTH  = mi3_pkg::DataWidthDef,
    parameter int FRAC_BITS   = mi3_pkg::FracBitsDef,
    parameter int QUEUE_DEPTH = mi3_pkg::QueueDepthDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  mi3_pkg::t_mat_in  i_item,
    output logic              empty,
    input  logic              pop,
    output mi3_pkg::t_inv_out o_item
);
    import mi3_pkg::*;

    // Queue entry: nine cofactors followed by the determinant.
    localparam int QW = 9 * (2 * DATA_WIDTH + 1) + 3 * DATA_WIDTH + 3;

    logic          w_front_en;
    logic          w_qpush;
    logic          w_qpop;
    logic [QW-1:0] w_qin;
    logic [QW-1:0] w_qout;
    t_fifo_stat    w_qstat;

    // The front stalls as a whole, so its input stage is free exactly when
    // the pipeline may advance.
    assign full = !w_front_en;

    mi3_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_en    (w_front_en),
        .i_item  (i_item),
        .i_qstat (w_qstat),
        .o_qpush (w_qpush),
        .o_qdata (w_qin)
    );

    mi3_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_qpush),
        .i_data  (w_qin),
        .i_pop   (w_qpop),
        .o_data  (w_qout),
        .o_stat  (w_qstat)
    );

    mi3_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (w_qstat),
        .i_qdata (w_qout),
        .o_qpop  (w_qpop),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (o_item)
    );

    // Input backpressure only ever comes from a full queue.
    a_full_from_queue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_qstat.full)
        else $error("input stalled while the queue had room");

    // A singular result carries no saturation and zero diagonal elements.
    a_singular_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.singular) |-> (!o_item.saturated &&
            o_item.inv_00 == 32'sd0 && o_item.inv_11 == 32'sd0 &&
            o_item.inv_22 == 32'sd0))
        else $error("singular item with nonzero fields");

    // The queue never reports full and empty at once.
    a_queue_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !w_qstat.empty)
        else $error("queue status inconsistent");

endmodule
